>>> sv/cdq_pkg.sv
// cdq_pkg: opcodes, configuration constants and status type for the circular deque.
// Depends on nothing; imported by cdq_ctrl, circular_deque_core and tb.
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int OPCODE_W  = 3;
   localparam int CSR_W     = 5;
   localparam int CAP_RESET = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_HEAD = 3'd0,
      OP_PUSH_TAIL = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_PEEK_HEAD = 3'd4,
      OP_PEEK_TAIL = 3'd5
   } opcode_type;

   typedef struct packed {
      logic ok;
      logic is_read;
      logic is_empty;
      logic is_full;
   } status_type;

endpackage

>>> sv/circular_deque_core.sv
// circular_deque_core: bounded double-ended queue in a ring store, top level.
// Depends on cdq_pkg, cdq_ctrl and cdq_ram.
//
//   channel  direction  ports                                   accepted when
//   req      in         req_opcode, req_push_value              req_valid & req_ready
//   rsp      out        rsp_ok, rsp_read_value, rsp_count_after,
//                       rsp_is_empty, rsp_is_full               rsp_valid & rsp_ready
//   csr      in         csr_wr_data                             csr_wr_en
//
// One item per cycle sustained while the output is not stalled. The store read issued at
// accept lands in the store's read register while the status waits in a result stage;
// both move into the output register when it is free or being read.
// Index and count update at accept, so the next item sees them at once. Reset empties
// the queue and sets capacity to min(16, DEPTH).
// A stalled output holds the result stage, and req_ready drops once both are full.
`timescale 1ns / 1ps

module circular_deque_core
   import cdq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [OPCODE_W-1:0]         req_opcode,
   input  logic [DATA_WIDTH-1:0]       req_push_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic [DATA_WIDTH-1:0]       rsp_read_value,
   output logic [$clog2(DEPTH+1)-1:0]  rsp_count_after,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full,
   input  logic                        csr_wr_en,
   input  logic [CSR_W-1:0]            csr_wr_data
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic                  accept;
   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;
   status_type            status;
   logic [CNT_W-1:0]      count_after;

   logic                  s1_valid_ff;
   status_type            s1_status_ff;
   logic [CNT_W-1:0]      s1_count_ff;
   logic                  s1_advance;

   logic                  rsp_valid_ff;
   logic                  rsp_ok_ff;
   logic [DATA_WIDTH-1:0] rsp_read_value_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  rsp_empty_ff;
   logic                  rsp_full_ff;

   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready  = ~s1_valid_ff | s1_advance;
   assign accept     = req_valid & req_ready;

   cdq_ctrl #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .opcode      (req_opcode),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_we      (mem_we),
      .mem_re      (mem_re),
      .mem_addr    (mem_addr),
      .status      (status),
      .count_after (count_after)
   );

   cdq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (req_push_value),
      .rd_data (mem_rd_data)
   );

   // result stage: waits for the store read, holds while the output is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_status_ff <= status;
         s1_count_ff  <= count_after;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_advance) begin
         rsp_ok_ff         <= s1_status_ff.ok;
         rsp_read_value_ff <= s1_status_ff.is_read ? mem_rd_data : '0;
         rsp_count_ff      <= s1_count_ff;
         rsp_empty_ff      <= s1_status_ff.is_empty;
         rsp_full_ff       <= s1_status_ff.is_full;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

endmodule

>>> sv/cdq_ram.sv
// cdq_ram: ring store, one write and one registered read per cycle.
// Depends on nothing; instantiated by circular_deque_core.
`timescale 1ns / 1ps

module cdq_ram #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int ADDR_W     = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/cdq_ctrl.sv
// cdq_ctrl: front index, element count and capacity; decodes an item into a store access.
// Depends on cdq_pkg; instantiated by circular_deque_core.
`timescale 1ns / 1ps

module cdq_ctrl
   import cdq_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int CNT_W  = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [OPCODE_W-1:0] opcode,
   input  logic                csr_wr_en,
   input  logic [CSR_W-1:0]    csr_wr_data,
   output logic                mem_we,
   output logic                mem_re,
   output logic [ADDR_W-1:0]   mem_addr,
   output status_type          status,
   output logic [CNT_W-1:0]    count_after
);

   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int CAP_RST_INT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_RST   = CNT_W'(CAP_RST_INT);

   logic [ADDR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  cap_clamped;
   logic [CMP_W-1:0]  csr_ext;

   logic [SUM_W-1:0]  front_ext, count_ext, cap_ext;
   logic [SUM_W-1:0]  sum_back, sum_tail, sum_inc;
   logic [ADDR_W-1:0] back_idx, tail_idx, inc_idx, dec_idx;
   logic              full, empty;
   logic              ok, we, re;
   logic [ADDR_W-1:0] addr;

   // clamp the written capacity into 1..DEPTH
   always_comb begin
      csr_ext = CMP_W'(csr_wr_data);
      if (csr_ext == '0) begin
         cap_clamped = CNT_W'(1);
      end else if (csr_ext > DEPTH_CMP) begin
         cap_clamped = CNT_W'(DEPTH);
      end else begin
         cap_clamped = CNT_W'(csr_ext);
      end
   end

   // index arithmetic, wrapped by one compare and subtract
   always_comb begin
      front_ext = SUM_W'(front_ff);
      count_ext = SUM_W'(count_ff);
      cap_ext   = SUM_W'(cap_ff);
      full      = (count_ff >= cap_ff);
      empty     = (count_ff == '0);

      sum_back = front_ext + count_ext - SUM_W'(1);
      if (sum_back >= cap_ext) begin
         sum_back = sum_back - cap_ext;
      end
      sum_tail = front_ext + count_ext;
      if (sum_tail >= cap_ext) begin
         sum_tail = sum_tail - cap_ext;
      end
      sum_inc = front_ext + SUM_W'(1);
      if (sum_inc >= cap_ext) begin
         sum_inc = sum_inc - cap_ext;
      end

      back_idx = empty ? front_ff : ADDR_W'(sum_back);
      tail_idx = ADDR_W'(sum_tail);
      inc_idx  = ADDR_W'(sum_inc);
      dec_idx  = (front_ff == '0) ? ADDR_W'(cap_ext - SUM_W'(1)) : front_ff - ADDR_W'(1);
   end

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      ok       = 1'b0;
      we       = 1'b0;
      re       = 1'b0;
      addr     = front_ff;
      unique case (opcode_type'(opcode))
         OP_PUSH_HEAD: begin
            if (!full) begin
               front_in = dec_idx;
               addr     = dec_idx;
               we       = 1'b1;
               count_in = count_ff + CNT_W'(1);
               ok       = 1'b1;
            end
         end
         OP_PUSH_TAIL: begin
            if (!full) begin
               addr     = tail_idx;
               we       = 1'b1;
               count_in = count_ff + CNT_W'(1);
               ok       = 1'b1;
            end
         end
         OP_POP_HEAD: begin
            if (!empty) begin
               re       = 1'b1;
               front_in = inc_idx;
               count_in = count_ff - CNT_W'(1);
               ok       = 1'b1;
            end
         end
         OP_POP_TAIL: begin
            if (!empty) begin
               addr     = back_idx;
               re       = 1'b1;
               count_in = count_ff - CNT_W'(1);
               ok       = 1'b1;
            end
         end
         OP_PEEK_HEAD: begin
            if (!empty) begin
               re = 1'b1;
               ok = 1'b1;
            end
         end
         OP_PEEK_TAIL: begin
            if (!empty) begin
               addr = back_idx;
               re   = 1'b1;
               ok   = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_RST;
      end else if (csr_wr_en) begin
         front_ff <= '0;
         count_ff <= '0;
         cap_ff   <= cap_clamped;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   assign mem_we          = accept & we;
   assign mem_re          = accept & re;
   assign mem_addr        = addr;
   assign count_after     = count_in;
   assign status.ok       = ok;
   assign status.is_read  = re;
   assign status.is_empty = (count_in == '0);
   assign status.is_full  = (count_in == cap_ff);

endmodule

>>> verif/tb.sv
// tb: self-checking testbench for circular_deque_core, a bounded deque kept in a ring store.
// Depends on cdq_pkg and circular_deque_core; the scoreboard class predicts every response.
`timescale 1ns / 1ps

module tb
   import cdq_pkg::*;
();

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 12;
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_ITEMS = 88;

   localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

   localparam logic [CSR_W-1:0] CAP_ZERO    = 5'd0;
   localparam logic [CSR_W-1:0] CAP_ONE     = 5'd1;
   localparam logic [CSR_W-1:0] CAP_FULL    = 5'd16;
   localparam logic [CSR_W-1:0] CAP_OVER    = 5'd17;
   localparam logic [CSR_W-1:0] CAP_REG_MAX = 5'd31;

   typedef struct packed {
      logic                  ok;
      logic [DATA_WIDTH-1:0] read_value;
      logic [COUNT_W-1:0]    count_after;
      logic                  is_empty;
      logic                  is_full;
   } result_type;

   class deque_scoreboard_type;
      logic [DATA_WIDTH-1:0] ring [DEPTH];
      int front_idx;
      int depth_used;
      int capacity_reg;
      result_type predicted_results[$];
      int mismatch_count;
      int request_count;
      int checked_count;
      int refused_count;
      int config_count;

      function new();
         front_idx    = 0;
         depth_used   = 0;
         capacity_reg = CAP_RESET;
      endfunction

      function int span();
         if (capacity_reg < 1)
            return 1;
         if (capacity_reg > DEPTH)
            return DEPTH;
         return capacity_reg;
      endfunction

      function int pending();
         return predicted_results.size();
      endfunction

      function string show(result_type x);
         return $sformatf("ok=%0b read=%h count=%0d empty=%0b full=%0b", x.ok,
                          x.read_value, x.count_after, x.is_empty, x.is_full);
      endfunction

      function void set_capacity(logic [CSR_W-1:0] value);
         capacity_reg = value;
         front_idx    = 0;
         depth_used   = 0;
         config_count++;
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [DATA_WIDTH-1:0] value);
         int c;
         int back;
         int slot;
         bit full;
         bit empty;
         result_type r;
         c     = span();
         full  = depth_used >= c;
         empty = depth_used == 0;
         r     = '0;
         back  = front_idx;
         if (!empty) begin
            back = front_idx + depth_used - 1;
            if (back >= c)
               back -= c;
         end
         case (op)
            OP_PUSH_HEAD: begin
               if (!full) begin
                  front_idx = (front_idx == 0) ? c - 1 : front_idx - 1;
                  ring[front_idx] = value;
                  depth_used++;
                  r.ok = 1'b1;
               end
            end
            OP_PUSH_TAIL: begin
               if (!full) begin
                  slot = front_idx + depth_used;
                  if (slot >= c)
                     slot -= c;
                  ring[slot] = value;
                  depth_used++;
                  r.ok = 1'b1;
               end
            end
            OP_POP_HEAD: begin
               if (!empty) begin
                  r.read_value = ring[front_idx];
                  front_idx = (front_idx + 1 >= c) ? 0 : front_idx + 1;
                  depth_used--;
                  r.ok = 1'b1;
               end
            end
            OP_POP_TAIL: begin
               if (!empty) begin
                  r.read_value = ring[back];
                  depth_used--;
                  r.ok = 1'b1;
               end
            end
            OP_PEEK_HEAD: begin
               if (!empty) begin
                  r.read_value = ring[front_idx];
                  r.ok = 1'b1;
               end
            end
            OP_PEEK_TAIL: begin
               if (!empty) begin
                  r.read_value = ring[back];
                  r.ok = 1'b1;
               end
            end
            default: ;
         endcase
         r.count_after = depth_used[COUNT_W-1:0];
         r.is_empty    = depth_used == 0;
         r.is_full     = depth_used == c;
         if (!r.ok)
            refused_count++;
         request_count++;
         predicted_results = {predicted_results, r};
      endfunction

      function void check_response(logic ok, logic [DATA_WIDTH-1:0] read_value,
                                   logic [COUNT_W-1:0] count_after, logic is_empty,
                                   logic is_full);
         result_type got;
         result_type want;
         got = '{ok, read_value, count_after, is_empty, is_full};
         if (predicted_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response with none expected: %s", $realtime, show(got));
            return;
         end
         want = predicted_results[0];
         predicted_results.delete(0);
         checked_count++;
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: mismatch, expected %s, got %s", $realtime, show(want),
                        show(got));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode = '0;
   logic [DATA_WIDTH-1:0] req_push_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_ok;
   logic [DATA_WIDTH-1:0] rsp_read_value;
   logic [COUNT_W-1:0]    rsp_count_after;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_W-1:0]      csr_wr_data = '0;

   int  cycle_count = 0;
   int  stall_left = 0;
   bit  rx_steady = 1'b0;

   deque_scoreboard_type sb = new();

   circular_deque_core #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_count_after (rsp_count_after),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  sb.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // hold rsp_ready low for random stalls, mostly short
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (rx_steady || $urandom_range(0, 99) < 65) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_ok, rsp_read_value, rsp_count_after, rsp_is_empty, rsp_is_full);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_op(bit fill);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2)
         return OP_UNUSED_6;
      if (r < 4)
         return OP_UNUSED_7;
      if (fill) begin
         if (r < 34) return OP_PUSH_HEAD;
         if (r < 64) return OP_PUSH_TAIL;
         if (r < 74) return OP_POP_HEAD;
         if (r < 84) return OP_POP_TAIL;
         if (r < 92) return OP_PEEK_HEAD;
         return OP_PEEK_TAIL;
      end
      if (r < 16) return OP_PUSH_HEAD;
      if (r < 28) return OP_PUSH_TAIL;
      if (r < 58) return OP_POP_HEAD;
      if (r < 86) return OP_POP_TAIL;
      if (r < 93) return OP_PEEK_HEAD;
      return OP_PEEK_TAIL;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      return $urandom;
   endfunction

   task automatic send_item(logic [OPCODE_W-1:0] op, logic [DATA_WIDTH-1:0] value, bit steady);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, value);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_capacity(logic [CSR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_capacity(value);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random_phase(int n_items, bit steady);
      bit fill;
      fill = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         if (sb.depth_used >= sb.span() && $urandom_range(0, 3) == 0)
            fill = 1'b0;
         else if (sb.depth_used == 0 && $urandom_range(0, 3) == 0)
            fill = 1'b1;
         else if ($urandom_range(0, 99) < 3)
            fill = !fill;
         if (i == n_items / 2)
            drain_results();
         send_item(pick_op(fill), pick_value(), steady);
      end
   endtask

   initial begin
      logic [CSR_W-1:0] cap_plan [9];
      cap_plan = '{CAP_FULL, CAP_ONE, CAP_ZERO, CAP_REG_MAX, CAP_OVER, 5'd2, 5'd5,
                   5'($urandom_range(3, 15)), CAP_FULL};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty queue at reset capacity: reads refused, then three pushes read back until empty again
      send_item(OP_POP_HEAD, '0, 1'b0);
      send_item(OP_POP_TAIL, '0, 1'b0);
      send_item(OP_PEEK_HEAD, '0, 1'b0);
      send_item(OP_PEEK_TAIL, '0, 1'b0);
      send_item(OP_UNUSED_6, '1, 1'b0);
      send_item(OP_UNUSED_7, '1, 1'b0);
      send_item(OP_PUSH_TAIL, '0, 1'b0);
      send_item(OP_PUSH_HEAD, '1, 1'b0);
      send_item(OP_PUSH_TAIL, 32'hA5A5_A5A5, 1'b0);
      send_item(OP_UNUSED_7, 32'h5A5A_5A5A, 1'b0);
      send_item(OP_PEEK_HEAD, '0, 1'b0);
      send_item(OP_PEEK_TAIL, '0, 1'b0);
      send_item(OP_POP_TAIL, '0, 1'b0);
      send_item(OP_POP_HEAD, '0, 1'b0);
      send_item(OP_POP_HEAD, '0, 1'b0);
      send_item(OP_POP_TAIL, '0, 1'b0);

      // single-entry ring: full after one push, front wrap at index zero
      drain_results();
      write_capacity(CAP_ONE);
      send_item(OP_PUSH_TAIL, 32'h1234_5678, 1'b0);
      send_item(OP_PUSH_HEAD, 32'hDEAD_BEEF, 1'b0);
      send_item(OP_POP_TAIL, '0, 1'b0);
      send_item(OP_PUSH_HEAD, 32'h8000_0001, 1'b0);
      send_item(OP_PEEK_TAIL, '0, 1'b0);
      send_item(OP_POP_HEAD, '0, 1'b0);
      send_item(OP_PUSH_HEAD, 32'h7FFF_FFFE, 1'b0);

      for (int p = 0; p < 9; p++) begin
         drain_results();
         write_capacity(cap_plan[p]);
         rx_steady = (p % 4 == 2);
         run_random_phase(PHASE_ITEMS, p % 3 == 1);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d refused) over %0d capacity writes incl. 0, 1, 16, 17, 31",
               sb.request_count, sb.refused_count, sb.config_count);
      $display("Checked %0d responses: %0d mismatches, %0d still outstanding",
               sb.checked_count, sb.mismatch_count, sb.pending());
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
